/* rtl/mqsb_pkg.sv */
// ----------------------------------------------------------------------------
// mqsb_pkg
// Shared types and constants for the multi-queue shared buffer.
// ----------------------------------------------------------------------------
package mqsb_pkg;

   localparam int DEPTH  = 16;
   localparam int QUEUES = 4;

   localparam int PTR_W  = $clog2(DEPTH);
   localparam int CNT_W  = $clog2(DEPTH + 1);
   localparam int QIX_W  = (QUEUES > 1) ? $clog2(QUEUES) : 1;
   localparam int QID_W  = 2;
   localparam int DATA_W = 32;

   typedef enum logic {
      OP_ENQUEUE = 1'b0,
      OP_DEQUEUE = 1'b1
   } op_type;

   typedef enum logic [1:0] {
      STATUS_OK        = 2'd0,
      STATUS_OVERFLOW  = 2'd1,
      STATUS_UNDERFLOW = 2'd2
   } status_type;

   typedef enum logic {
      CTRL_IDLE = 1'b0,
      CTRL_LINK = 1'b1
   } ctrl_state_type;

   typedef struct packed {
      logic accept;
      logic finish;
   } cmd_type;

endpackage

/* rtl/mqsb_req_if.sv */
// ----------------------------------------------------------------------------
// mqsb_req_if
// Request channel: one queue operation per item.
// ----------------------------------------------------------------------------
interface mqsb_req_if;
   logic                                valid;
   logic                                ready;
   logic                                op;
   logic [mqsb_pkg::QID_W-1:0]          queue_id;
   logic signed [mqsb_pkg::DATA_W-1:0]  value;

   modport source (output valid, output op, output queue_id, output value, input ready);
   modport sink   (input valid, input op, input queue_id, input value, output ready);
endinterface

/* rtl/mqsb_rsp_if.sv */
// ----------------------------------------------------------------------------
// mqsb_rsp_if
// Response channel: one result item per request.
// ----------------------------------------------------------------------------
interface mqsb_rsp_if;
   logic                                valid;
   logic                                ready;
   logic signed [mqsb_pkg::DATA_W-1:0]  data_out;
   logic [1:0]                          status;
   logic                                queue_empty;
   logic                                buffer_full;

   modport source (output valid, output data_out, output status, output queue_empty,
                   output buffer_full, input ready);
   modport sink   (input valid, input data_out, input status, input queue_empty,
                   input buffer_full, output ready);
endinterface

/* rtl/mqsb_ctrl.sv */
// ----------------------------------------------------------------------------
// mqsb_ctrl
// Sequencer: accepts a request, runs the link-resolve cycle, holds the
// response valid until it is taken.
// ----------------------------------------------------------------------------
module mqsb_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output mqsb_pkg::cmd_type  cmd
);

   mqsb_pkg::ctrl_state_type state_ff, state_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic                     out_free;

   assign out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         mqsb_pkg::CTRL_IDLE: begin
            if (req_valid && out_free) begin
               state_in = mqsb_pkg::CTRL_LINK;
            end
         end
         mqsb_pkg::CTRL_LINK: begin
            state_in = mqsb_pkg::CTRL_IDLE;
         end
         default: begin
            state_in = mqsb_pkg::CTRL_IDLE;
         end
      endcase
   end

   always_comb begin
      req_ready  = 1'b0;
      cmd.accept = 1'b0;
      cmd.finish = 1'b0;
      case (state_ff)
         mqsb_pkg::CTRL_IDLE: begin
            req_ready  = out_free;
            cmd.accept = req_valid && out_free;
         end
         mqsb_pkg::CTRL_LINK: begin
            cmd.finish = 1'b1;
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

   // load on finish, drop once taken
   assign rsp_valid_in = cmd.finish || (rsp_valid_ff && !rsp_ready);
   assign rsp_valid    = rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= mqsb_pkg::CTRL_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

/* rtl/mqsb_datapath.sv */
// ----------------------------------------------------------------------------
// mqsb_datapath
// Queue head/tail pointers, free list, link and data stores, and the
// response register.
// ----------------------------------------------------------------------------
module mqsb_datapath (
   input  logic                                clock,
   input  logic                                reset,
   input  mqsb_pkg::cmd_type                   cmd,
   input  logic                                req_op,
   input  logic [mqsb_pkg::QID_W-1:0]          req_queue_id,
   input  logic signed [mqsb_pkg::DATA_W-1:0]  req_value,
   output logic signed [mqsb_pkg::DATA_W-1:0]  rsp_data_out,
   output logic [1:0]                          rsp_status,
   output logic                                rsp_queue_empty,
   output logic                                rsp_buffer_full
);

   localparam int PTR_W  = mqsb_pkg::PTR_W;
   localparam int CNT_W  = mqsb_pkg::CNT_W;
   localparam int QIX_W  = mqsb_pkg::QIX_W;
   localparam int DATA_W = mqsb_pkg::DATA_W;
   localparam int DEPTH  = mqsb_pkg::DEPTH;
   localparam int QUEUES = mqsb_pkg::QUEUES;

   // queue and free-list state
   logic [PTR_W-1:0]  head_ff [QUEUES];
   logic [PTR_W-1:0]  tail_ff [QUEUES];
   logic [QUEUES-1:0] qv_ff;
   logic [PTR_W-1:0]  free_head_ff;
   logic [CNT_W-1:0]  free_count_ff;

   // stores
   logic [DATA_W-1:0] data_mem [DEPTH];
   logic [PTR_W-1:0]  link_mem [DEPTH];
   logic [DEPTH-1:0]  link_wr_ff;

   // per-item registers between the accept and link-resolve steps
   logic              op_ff;
   logic [QIX_W-1:0]  qidx_ff;
   logic              in_range_ff;
   logic              ok_ff;
   logic              last_ff;
   logic [PTR_W-1:0]  link_addr_ff;
   logic [PTR_W-1:0]  link_rd_ff;
   logic              link_set_ff;
   logic [DATA_W-1:0] data_rd_ff;

   // response register
   logic signed [DATA_W-1:0] data_out_ff;
   logic [1:0]               status_ff;
   logic                     queue_empty_ff;
   logic                     buffer_full_ff;

   logic [QIX_W-1:0] qidx;
   logic             in_range;
   logic             is_deq;
   logic             q_nonempty;
   logic             free_ok;
   logic             enq_ok;
   logic             deq_ok;
   logic             last;
   logic [PTR_W-1:0] slot;
   logic             link_we;
   logic [PTR_W-1:0] link_wa;
   logic [PTR_W-1:0] link_wd;
   logic [PTR_W-1:0] link_next;
   mqsb_pkg::status_type status_next;

   assign qidx       = QIX_W'(req_queue_id);
   assign in_range   = int'(req_queue_id) < QUEUES;
   assign is_deq     = req_op == mqsb_pkg::OP_DEQUEUE;
   assign q_nonempty = qv_ff[qidx];
   assign free_ok    = free_count_ff != '0;
   assign enq_ok     = !is_deq && in_range && free_ok;
   assign deq_ok     = is_deq && in_range && q_nonempty;
   assign last       = head_ff[qidx] == tail_ff[qidx];
   assign slot       = is_deq ? head_ff[qidx] : free_head_ff;

   // enqueue links the old tail to the new slot; dequeue pushes the slot on the free list
   assign link_we = (enq_ok && q_nonempty) || deq_ok;
   assign link_wa = deq_ok ? slot : tail_ff[qidx];
   assign link_wd = deq_ok ? free_head_ff : slot;

   // entries never written are read as the reset chain to the next slot
   assign link_next = link_set_ff ? link_rd_ff : link_addr_ff + PTR_W'(1);

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         link_rd_ff <= link_mem[slot];
         data_rd_ff <= data_mem[slot];
         if (link_we) begin
            link_mem[link_wa] <= link_wd;
         end
         if (enq_ok) begin
            data_mem[slot] <= req_value;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         link_wr_ff <= '0;
      end else if (cmd.accept && link_we) begin
         link_wr_ff[link_wa] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         op_ff        <= is_deq;
         qidx_ff      <= qidx;
         in_range_ff  <= in_range;
         ok_ff        <= enq_ok || deq_ok;
         last_ff      <= last;
         link_addr_ff <= slot;
         link_set_ff  <= link_wr_ff[slot];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < QUEUES; i++) begin
            head_ff[i] <= '0;
            tail_ff[i] <= '0;
         end
         qv_ff         <= '0;
         free_head_ff  <= '0;
         free_count_ff <= CNT_W'(DEPTH);
      end else if (cmd.accept) begin
         if (enq_ok) begin
            tail_ff[qidx] <= slot;
            if (!q_nonempty) begin
               head_ff[qidx] <= slot;
            end
            qv_ff[qidx]   <= 1'b1;
            free_count_ff <= free_count_ff - CNT_W'(1);
         end else if (deq_ok) begin
            free_head_ff  <= slot;
            free_count_ff <= free_count_ff + CNT_W'(1);
            if (last) begin
               qv_ff[qidx] <= 1'b0;
            end
         end
      end else if (cmd.finish && ok_ff) begin
         // advance the free head or the queue head through the link just read
         if (!op_ff) begin
            free_head_ff <= link_next;
         end else if (!last_ff) begin
            head_ff[qidx_ff] <= link_next;
         end
      end
   end

   always_comb begin
      if (ok_ff) begin
         status_next = mqsb_pkg::STATUS_OK;
      end else if (op_ff) begin
         status_next = mqsb_pkg::STATUS_UNDERFLOW;
      end else begin
         status_next = mqsb_pkg::STATUS_OVERFLOW;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.finish) begin
         data_out_ff    <= (ok_ff && op_ff) ? data_rd_ff : '0;
         status_ff      <= status_next;
         queue_empty_ff <= !in_range_ff || !qv_ff[qidx_ff];
         buffer_full_ff <= free_count_ff == '0;
      end
   end

   assign rsp_data_out    = data_out_ff;
   assign rsp_status      = status_ff;
   assign rsp_queue_empty = queue_empty_ff;
   assign rsp_buffer_full = buffer_full_ff;

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      free_count_ff <= CNT_W'(DEPTH))
      else $error("free count exceeds buffer depth");

   a_enq_takes_slot: assert property (@(posedge clock) disable iff (reset)
      cmd.accept && enq_ok |=> free_count_ff == $past(free_count_ff) - CNT_W'(1))
      else $error("enqueue did not take a free slot");

   a_all_empty_all_free: assert property (@(posedge clock) disable iff (reset)
      qv_ff == '0 |-> free_count_ff == CNT_W'(DEPTH))
      else $error("slots lost while every queue is empty");

   a_finish_after_accept: assert property (@(posedge clock) disable iff (reset)
      cmd.finish |-> $past(cmd.accept))
      else $error("finish without a preceding accept");

endmodule

/* rtl/multi_queue_shared_buffer.sv */
// ----------------------------------------------------------------------------
// multi_queue_shared_buffer
// Several FIFO queues kept as linked lists in one shared slot store, with
// unused slots on a free list.
// ----------------------------------------------------------------------------
//   channel   dir   payload
//   req_ch    in    op, queue_id, value
//   rsp_ch    out   data_out, status, queue_empty, buffer_full
//
// For each item, the accept cycle updates pointers and issues the
// link and data store reads, the next cycle resolves the new free or queue head
// from the registered link read and loads the response register.
// A new item is taken in the cycle after that, provided the response register
// is empty or being drained. Reset is synchronous; no clearing pass is needed,
// as per-slot written bits stand in for the initial free chain.
// ----------------------------------------------------------------------------
module multi_queue_shared_buffer (
   input  logic       clock,
   input  logic       reset,
   mqsb_req_if.sink   req_ch,
   mqsb_rsp_if.source rsp_ch
);

   mqsb_pkg::cmd_type cmd;

   mqsb_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .rsp_valid (rsp_ch.valid),
      .rsp_ready (rsp_ch.ready),
      .cmd       (cmd)
   );

   mqsb_datapath u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .req_op          (req_ch.op),
      .req_queue_id    (req_ch.queue_id),
      .req_value       (req_ch.value),
      .rsp_data_out    (rsp_ch.data_out),
      .rsp_status      (rsp_ch.status),
      .rsp_queue_empty (rsp_ch.queue_empty),
      .rsp_buffer_full (rsp_ch.buffer_full)
   );

endmodule
